// File: rtl/refslot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refslot_pkg
// Shared constants for the reference slot table: default capacity, result
// field widths, opcodes, status and count-adjust codes.
// ----------------------------------------------------------------------------
package refslot_pkg;

  // default number of slots
  localparam int DEF_CAPACITY = 64;

  // reference word and slot entry widths
  localparam int REF_W   = 32;
  localparam int ENTRY_W = REF_W + 1;

  // result field widths
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int ADJ_W    = 2;

  // opcodes
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SKIPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // reference count adjust codes
  localparam logic [ADJ_W-1:0] ADJ_NONE = 2'd0;
  localparam logic [ADJ_W-1:0] ADJ_UP   = 2'd1;
  localparam logic [ADJ_W-1:0] ADJ_DOWN = 2'd2;

endpackage

// File: rtl/reference_slot_table_core.sv
`timescale 1ns / 1ps
// Steps: a skipped or full word goes straight to the result; an add reads and
//   then writes the head free slot; a remove scans the store in index order.
// Throughput: one word at a time; the next word is taken only after the result
//   word is loaded, and a remove walks the slot store one entry per cycle
//   through the single read port.
// Reset: after rst_n the slot store is cleared to the free chain, during which
//   in_ready stays low.
// ----------------------------------------------------------------------------
// reference_slot_table_core
// Fixed table of object-reference slots with an embedded free list.
// ----------------------------------------------------------------------------
module reference_slot_table_core #(
  parameter int CAPACITY = refslot_pkg::DEF_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_opcode,
  input  logic [refslot_pkg::REF_W-1:0]    in_object_ref,
  input  logic                             in_is_immediate,
  input  logic                             in_is_permanent,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [refslot_pkg::STATUS_W-1:0] out_status,
  output logic [refslot_pkg::SLOT_W-1:0]   out_slot_index,
  output logic [refslot_pkg::ADJ_W-1:0]    out_ref_adjust
);
  import refslot_pkg::*;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int HEAD_W = $clog2(CAPACITY + 1);

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  // sequencer
  refslot_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .HEAD_W   (HEAD_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_object_ref   (in_object_ref),
    .in_is_immediate (in_is_immediate),
    .in_is_permanent (in_is_permanent),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot_index  (out_slot_index),
    .out_ref_adjust  (out_ref_adjust),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

  // slot store
  refslot_mem #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: rtl/refslot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refslot_mem
// Slot store: one write port, one read port, read data registered. Bit 32
// is the occupied flag, bits 31..0 hold the reference or the next free link.
// ----------------------------------------------------------------------------
module refslot_mem #(
  parameter int CAPACITY = refslot_pkg::DEF_CAPACITY,
  parameter int IDX_W    = $clog2(CAPACITY)
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [IDX_W-1:0]               wr_addr,
  input  logic [refslot_pkg::ENTRY_W-1:0] wr_data,
  input  logic [IDX_W-1:0]               rd_addr,
  output logic [refslot_pkg::ENTRY_W-1:0] rd_data
);
  import refslot_pkg::*;

  logic [ENTRY_W-1:0] mem [CAPACITY];
  logic [ENTRY_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/refslot_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refslot_ctrl
// Sequencer for the slot table: clears the store after reset, pops the free
// head on add, scans the store in index order on remove, keeps the free
// head and drives the registered result word.
// ----------------------------------------------------------------------------
module refslot_ctrl #(
  parameter int CAPACITY = refslot_pkg::DEF_CAPACITY,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int HEAD_W   = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input word
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_opcode,
  input  logic [refslot_pkg::REF_W-1:0]     in_object_ref,
  input  logic                              in_is_immediate,
  input  logic                              in_is_permanent,
  // result word
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [refslot_pkg::STATUS_W-1:0]  out_status,
  output logic [refslot_pkg::SLOT_W-1:0]    out_slot_index,
  output logic [refslot_pkg::ADJ_W-1:0]     out_ref_adjust,
  // slot store
  output logic                              wr_en,
  output logic [IDX_W-1:0]                  wr_addr,
  output logic [refslot_pkg::ENTRY_W-1:0]   wr_data,
  output logic [IDX_W-1:0]                  rd_addr,
  input  logic [refslot_pkg::ENTRY_W-1:0]   rd_data
);
  import refslot_pkg::*;

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [HEAD_W-1:0] END_LINK = HEAD_W'(CAPACITY);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_ADD_RD = 6'b000100,
    S_ADD_WR = 6'b001000,
    S_SCAN   = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [HEAD_W-1:0]    head_r, head_nxt;
  logic [IDX_W-1:0]     clr_idx_r, clr_idx_nxt;
  logic [IDX_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 load_out;
  logic                 accept;
  logic                 res_load;

  // payload registers
  logic [REF_W-1:0]     ref_r;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]    res_slot_r, res_slot_nxt;
  logic [ADJ_W-1:0]     res_adj_r, res_adj_nxt;
  logic [STATUS_W-1:0]  out_status_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [ADJ_W-1:0]     out_adj_r;

  logic [HEAD_W-1:0]    link_clamped;
  logic                 slot_match;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == S_RESULT) && (!out_valid_r || out_ready);

  // clamp a stored link to end of list
  assign link_clamped = (rd_data[REF_W-1:0] > REF_W'(CAPACITY)) ? END_LINK
                                                               : HEAD_W'(rd_data[REF_W-1:0]);
  assign slot_match   = rd_data[REF_W] && (rd_data[REF_W-1:0] == ref_r);

  // next state and store access
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    clr_idx_nxt    = clr_idx_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    res_load       = 1'b0;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_adj_nxt    = res_adj_r;
    wr_en          = 1'b0;
    wr_addr        = clr_idx_r;
    wr_data        = '0;
    rd_addr        = scan_idx_r;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx_r;
        wr_data = {1'b0, REF_W'(clr_idx_r) + REF_W'(1)};
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          if (in_is_immediate || in_is_permanent) begin
            res_status_nxt = ST_SKIPPED;
            res_slot_nxt   = '0;
            res_adj_nxt    = ADJ_NONE;
            state_nxt      = S_RESULT;
          end else if (in_opcode == OP_ADD) begin
            if (head_r == END_LINK) begin
              res_status_nxt = ST_FULL;
              res_slot_nxt   = '0;
              res_adj_nxt    = ADJ_NONE;
              state_nxt      = S_RESULT;
            end else begin
              state_nxt = S_ADD_RD;
            end
          end else begin
            scan_idx_nxt = '0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_ADD_RD: begin
        // fetch the link held in the head free slot
        rd_addr   = head_r[IDX_W-1:0];
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        wr_en          = 1'b1;
        wr_addr        = head_r[IDX_W-1:0];
        wr_data        = {1'b1, ref_r};
        head_nxt       = link_clamped;
        res_load       = 1'b1;
        res_status_nxt = ST_STORED;
        res_slot_nxt   = SLOT_W'(head_r[IDX_W-1:0]);
        res_adj_nxt    = ADJ_UP;
        state_nxt      = S_RESULT;
      end
      S_SCAN: begin
        // issue one read per cycle, compare the previous one
        rd_addr      = scan_idx_r;
        cmp_vld_nxt  = 1'b1;
        cmp_idx_nxt  = scan_idx_r;
        scan_idx_nxt = (scan_idx_r == LAST_IDX) ? scan_idx_r : scan_idx_r + IDX_W'(1);
        if (cmp_vld_r && slot_match) begin
          wr_en          = 1'b1;
          wr_addr        = cmp_idx_r;
          wr_data        = {1'b0, REF_W'(head_r)};
          head_nxt       = HEAD_W'(cmp_idx_r);
          res_load       = 1'b1;
          res_status_nxt = ST_REMOVED;
          res_slot_nxt   = SLOT_W'(cmp_idx_r);
          res_adj_nxt    = ADJ_DOWN;
          state_nxt      = S_RESULT;
        end else if (cmp_vld_r && (cmp_idx_r == LAST_IDX)) begin
          res_load       = 1'b1;
          res_status_nxt = ST_NOTFOUND;
          res_slot_nxt   = '0;
          res_adj_nxt    = ADJ_DOWN;
          state_nxt      = S_RESULT;
        end
      end
      S_RESULT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid: set on load, drop on take
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      head_r      <= '0;
      clr_idx_r   <= '0;
      scan_idx_r  <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      clr_idx_r   <= clr_idx_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    if (accept) begin
      ref_r <= in_object_ref;
    end
    if (res_load) begin
      res_status_r <= res_status_nxt;
      res_slot_r   <= res_slot_nxt;
      res_adj_r    <= res_adj_nxt;
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_adj_r    <= res_adj_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;
  assign out_ref_adjust = out_adj_r;

endmodule

// File: rtl/refslot_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refslot_chk
// Port-level checks for the reference slot table, bound to the top level.
// ----------------------------------------------------------------------------
module refslot_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [refslot_pkg::STATUS_W-1:0] out_status,
  input logic [refslot_pkg::SLOT_W-1:0]   out_slot_index,
  input logic [refslot_pkg::ADJ_W-1:0]    out_ref_adjust
);
  import refslot_pkg::*;

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_slot_index) && $stable(out_ref_adjust))
    else $error("result word changed while stalled");

  // count adjust follows the status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((out_status == ST_STORED) && (out_ref_adjust == ADJ_UP)) ||
      ((out_status == ST_REMOVED) && (out_ref_adjust == ADJ_DOWN)) ||
      ((out_status == ST_NOTFOUND) && (out_ref_adjust == ADJ_DOWN)) ||
      ((out_status == ST_SKIPPED) && (out_ref_adjust == ADJ_NONE)) ||
      ((out_status == ST_FULL) && (out_ref_adjust == ADJ_NONE)))
    else $error("status and count adjust disagree");

  // no slot reported when none was used
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_STORED) && (out_status != ST_REMOVED)
      |-> out_slot_index == '0)
    else $error("slot index set on a result without a slot");

  // reset empties the result side and holds off input during the clear
  assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("block active right after reset");

endmodule

bind reference_slot_table_core refslot_chk u_refslot_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_slot_index (out_slot_index),
  .out_ref_adjust (out_ref_adjust)
);
